// ----- hw/rtl/cau_pkg.sv -----
// Shared types, constants and helpers for the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned WIDE_W    = PROD_W + 1;
  localparam int unsigned SQ_STAGES = 4;
  localparam int unsigned SQ_ITERS  = 4;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_RSCL  = 3'd2,
    OP_ISCL  = 3'd3,
    OP_CMUL  = 3'd4,
    OP_MAG   = 3'd5
  } opcode_t;

  // restoring digit-by-digit square root state
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] root;
    logic [PROD_W-1:0] one;
  } sq_t;

  // results that ride alongside the root pipeline
  typedef struct packed {
    logic                     mag;
    logic                     sat;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } side_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } clip_t;

  localparam logic [PROD_W-1:0] SQ_ONE_INIT = PROD_W'(1) << (PROD_W - 2);
  localparam logic signed [DATA_W-1:0] S16_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S16_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic clip_t clip_wide(input logic signed [WIDE_W-1:0] x);
    clip_t r;
    if (x > WIDE_W'(S16_MAX)) begin
      r.sat = 1'b1;
      r.val = S16_MAX;
    end else if (x < WIDE_W'(S16_MIN)) begin
      r.sat = 1'b1;
      r.val = S16_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cau_sqrt_step.sv -----
// Four iterations of the digit-by-digit integer square root.
module cau_sqrt_step (
  input  cau_pkg::sq_t d_i,
  output cau_pkg::sq_t d_o
);
  import cau_pkg::*;

  always_comb begin
    sq_t               s;
    logic [PROD_W-1:0] trial;
    s = d_i;
    for (int k = 0; k < SQ_ITERS; k++) begin
      trial = s.root + s.one;
      if (s.rem >= trial) begin
        s.rem  = s.rem - trial;
        s.root = (s.root >> 1) + s.one;
      end else begin
        s.root = s.root >> 1;
      end
      s.one = s.one >> 2;
    end
    d_o = s;
  end

endmodule

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Complex ALU top level: operand capture, products, combine/clip and root pipeline.
//
// Usage:
//   Input beats on in_* carry an opcode in in_tuser and operands A and B in
//   in_tdata, all signed Q8.8. Each beat yields exactly one output beat on
//   out_*: the result in out_tdata and the saturation flag in out_tuser.
//   Opcodes: add, subtract, real scale, imaginary scale, complex multiply,
//   magnitude of A; unused codes return zero.
//   Every opcode passes through the same stages on its way to out_tvalid.
//   Throughput is one beat per cycle while out_tready is high: seven register
//   stages (operand capture, 16x16 multipliers, combine/shift/clip, and four
//   square-root stages of four iterations each) each hold one beat.
//   Every stage has its own valid bit; a stage moves when the stage after it
//   is empty or moving, so a stalled out_tready fills the bubbles first and
//   only then drops in_tready. Nothing is lost or repeated under stalls.
//   rst_n (synchronous, active low) empties the pipeline; no results are
//   pending afterwards and in_tready is high.
module complex_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // res_re[15:0], res_im[31:16]
  output logic [0:0]  out_tuser   // saturated[0]
);
  import cau_pkg::*;

  localparam int unsigned NSTG = 3 + SQ_STAGES;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // stage 0: operand capture
  opcode_t                  op0_r;
  logic signed [DATA_W-1:0] ar0_r, ai0_r, br0_r, bi0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      op0_r <= opcode_t'(in_tuser);
      ar0_r <= in_tdata[15:0];
      ai0_r <= in_tdata[31:16];
      br0_r <= in_tdata[47:32];
      bi0_r <= in_tdata[63:48];
    end
  end

  // stage 1: products; magnitude reuses the first two multipliers for squares
  opcode_t                  op1_r;
  logic signed [DATA_W-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [PROD_W-1:0] m0_r, m1_r, m2_r, m3_r;
  logic signed [DATA_W-1:0] m0_b, m1_b;

  assign m0_b = (op0_r == OP_MAG) ? ar0_r : br0_r;
  assign m1_b = (op0_r == OP_MAG) ? ai0_r : bi0_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      op1_r <= op0_r;
      ar1_r <= ar0_r;
      ai1_r <= ai0_r;
      br1_r <= br0_r;
      bi1_r <= bi0_r;
      m0_r  <= ar0_r * m0_b;
      m1_r  <= ai0_r * m1_b;
      m2_r  <= ar0_r * bi0_r;
      m3_r  <= ai0_r * br0_r;
    end
  end

  // stage 2: combine, floor shift, clip; seed the root
  logic signed [WIDE_W-1:0] pre_re, pre_im;
  logic [PROD_W-1:0]        sq_sum;
  clip_t                    c_re, c_im;
  side_t                    side_nxt;

  always_comb begin
    pre_re = '0;
    pre_im = '0;
    unique case (op1_r)
      OP_ADD: begin
        pre_re = WIDE_W'(ar1_r) + WIDE_W'(br1_r);
        pre_im = WIDE_W'(ai1_r) + WIDE_W'(bi1_r);
      end
      OP_SUB: begin
        pre_re = WIDE_W'(ar1_r) - WIDE_W'(br1_r);
        pre_im = WIDE_W'(ai1_r) - WIDE_W'(bi1_r);
      end
      OP_RSCL: begin
        pre_re = WIDE_W'(m0_r) >>> FRAC_BITS;
        pre_im = WIDE_W'(m3_r) >>> FRAC_BITS;
      end
      OP_ISCL: begin
        pre_re = (-WIDE_W'(m3_r)) >>> FRAC_BITS;
        pre_im = WIDE_W'(m0_r) >>> FRAC_BITS;
      end
      OP_CMUL: begin
        pre_re = (WIDE_W'(m0_r) - WIDE_W'(m1_r)) >>> FRAC_BITS;
        pre_im = (WIDE_W'(m2_r) + WIDE_W'(m3_r)) >>> FRAC_BITS;
      end
      OP_MAG: begin
        pre_re = '0;
        pre_im = '0;
      end
      default: begin
        pre_re = '0;
        pre_im = '0;
      end
    endcase
    c_re = clip_wide(pre_re);
    c_im = clip_wide(pre_im);
    // both squares are non-negative and their sum is at most 2^31
    sq_sum = $unsigned(m0_r) + $unsigned(m1_r);
    side_nxt.mag = (op1_r == OP_MAG);
    side_nxt.sat = c_re.sat || c_im.sat;
    side_nxt.re  = c_re.val;
    side_nxt.im  = c_im.val;
  end

  side_t sd_r [SQ_STAGES];
  sq_t   sq_r [SQ_STAGES];
  sq_t   sq_o [SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sd_r[0]      <= side_nxt;
      sq_r[0].rem  <= sq_sum;
      sq_r[0].root <= '0;
      sq_r[0].one  <= SQ_ONE_INIT;
    end
  end

  // stages 3 .. NSTG-2: root iterations, side results carried along
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
    cau_sqrt_step u_step (
      .d_i (sq_r[g]),
      .d_o (sq_o[g])
    );
    if (g < SQ_STAGES - 1) begin : g_reg
      always_ff @(posedge clk) begin
        if (rdy[g+3]) begin
          sd_r[g+1] <= sd_r[g];
          sq_r[g+1] <= sq_o[g];
        end
      end
    end
  end

  // output stage: pick the magnitude or the carried result
  logic                     mag_sat;
  logic signed [DATA_W-1:0] out_re_nxt, out_im_nxt;
  logic                     out_sat_nxt;
  logic signed [DATA_W-1:0] out_re_r, out_im_r;
  logic                     out_sat_r, out_mag_r;

  always_comb begin
    mag_sat = sq_o[SQ_STAGES-1].root > PROD_W'(S16_MAX);
    if (sd_r[SQ_STAGES-1].mag) begin
      out_re_nxt  = mag_sat ? S16_MAX : sq_o[SQ_STAGES-1].root[DATA_W-1:0];
      out_im_nxt  = '0;
      out_sat_nxt = mag_sat;
    end else begin
      out_re_nxt  = sd_r[SQ_STAGES-1].re;
      out_im_nxt  = sd_r[SQ_STAGES-1].im;
      out_sat_nxt = sd_r[SQ_STAGES-1].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      out_re_r  <= out_re_nxt;
      out_im_r  <= out_im_nxt;
      out_sat_r <= out_sat_nxt;
      out_mag_r <= sd_r[SQ_STAGES-1].mag;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {out_im_r, out_re_r};
  assign out_tuser  = out_sat_r;

  // a magnitude beat never carries an imaginary part
  a_mag_im_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_mag_r |-> out_im_r == '0)
    else $error("magnitude result with nonzero imaginary part");

  // the flag only comes with a clipped value
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_re_r == S16_MAX || out_re_r == S16_MIN ||
      out_im_r == S16_MAX || out_im_r == S16_MIN)
    else $error("saturation flag without a clipped part");

  // an empty capture stage always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_tready)
    else $error("input stalled with empty capture stage");

  // an accepted beat lands in the capture stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat lost at capture stage");

endmodule
